[src/wsra_pkg.sv]
package wsra_pkg;

    localparam int DEFAULT_WINDOW_LEN = 8;
    localparam int DEFAULT_WHEELS     = 4;

    localparam int NOW_W   = 48;
    localparam int WHEEL_W = 2;
    localparam int RPM_W   = 34;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // 60e6 us per minute, scaled by 256 for the Q.8 result.
    localparam logic [RPM_W-1:0] RPM_Q8_NUM = 34'd15360000000;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 32'd500000;
    localparam logic [CFG_W-1:0] STALE_RST    = 32'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE    = 1'b1;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

[src/wsra_in_if.sv]
interface wsra_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [wsra_pkg::WHEEL_W-1:0]  wheel;
    logic [wsra_pkg::NOW_W-1:0]    now_us;

    modport source(output valid, operation, wheel, now_us, input ready);
    modport sink(input valid, operation, wheel, now_us, output ready);
endinterface

[src/wsra_out_if.sv]
interface wsra_out_if;
    logic                        valid;
    logic                        ready;
    logic [wsra_pkg::RPM_W-1:0]  rpm_avg;
    logic                        edge_accepted;
    logic                        sample_added;

    modport source(output valid, rpm_avg, edge_accepted, sample_added, input ready);
    modport sink(input valid, rpm_avg, edge_accepted, sample_added, output ready);
endinterface

[src/wheel_speed_rpm_averager.sv]
// Multi-wheel hall-sensor tachometer. Each input beat is either a sensor edge
// (debounced per wheel, then turned into an rpm sample in Q.8 and pushed into
// that wheel's moving-average window) or a read that returns the averaged rpm,
// or zero when the window is empty or the last edge is older than the stale
// timeout. One beat is handled at a time and ready is low while it is in work.
// An edge that yields a sample, and a read of a fresh non-empty window, go
// through one shared restoring divider that retires one quotient bit per
// cycle. From input beat to output beat an edge that yields a sample passes
// through S_EVAL, S_DIV and S_UPD to S_OUT, and such a read skips S_UPD; the
// quotient has SUM_W = 34 + clog2(WINDOW_LEN) bits. Rejected edges, first
// edges and reads that return zero go from S_EVAL straight to S_OUT.
// The output beat sits in a register, so the next input can be taken while
// a result still waits. Sample storage needs no clearing after reset.
module wheel_speed_rpm_averager #(
    parameter int WINDOW_LEN = wsra_pkg::DEFAULT_WINDOW_LEN,
    parameter int WHEELS     = wsra_pkg::DEFAULT_WHEELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wsra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wsra_pkg::CFG_W-1:0]      i_cfg_data,
    wsra_in_if.sink                         i_in,
    wsra_out_if.source                      o_out
);

    localparam int NOW_W = wsra_pkg::NOW_W;
    localparam int RPM_W = wsra_pkg::RPM_W;
    localparam int SUM_W = RPM_W + $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int HD_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WI_W  = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int DEPTH = WHEELS * WINDOW_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DC_W  = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

    t_state r_state;

    logic [wsra_pkg::CFG_W-1:0] r_debounce;
    logic [wsra_pkg::CFG_W-1:0] r_stale;

    logic                       r_op;
    logic                       r_wheel_ok;
    logic [WI_W-1:0]            r_idx;
    logic [NOW_W-1:0]           r_now;

    logic [NOW_W-1:0]           r_last [WHEELS];
    logic [HD_W-1:0]            r_head [WHEELS];
    logic [CNT_W-1:0]           r_count[WHEELS];
    logic [SUM_W-1:0]           r_sum  [WHEELS];

    logic [RPM_W-1:0]           r_mem [DEPTH];
    logic [RPM_W-1:0]           r_mem_rd;

    // Shared divider.
    logic [SUM_W-1:0]           r_quo;
    logic [NOW_W-1:0]           r_dvs;
    logic [NOW_W:0]             r_rem;
    logic [DC_W-1:0]            r_dcnt;
    logic                       r_mode_sample;

    logic [RPM_W-1:0]           r_res_avg;
    logic                       r_res_acc;
    logic                       r_res_add;

    logic                       r_out_valid;
    logic [RPM_W-1:0]           r_out_avg;
    logic                       r_out_acc;
    logic                       r_out_add;

    logic [NOW_W-1:0]           w_last;
    logic [NOW_W:0]             w_diff;
    logic                       w_deb_gt;
    logic                       w_stale_gt;
    logic                       w_edge_acc;
    logic                       w_smp_start;
    logic                       w_avg_start;
    logic [NOW_W:0]             w_trial;
    logic                       w_fit;
    logic [RPM_W-1:0]           w_old;
    logic [SUM_W-1:0]           w_sum_next;
    logic [HD_W-1:0]            w_head_next;
    logic [AW-1:0]              w_addr;
    logic                       w_mem_we;
    logic                       w_in_acc;

    assign w_in_acc = i_in.valid && i_in.ready;

    assign w_last = r_last[r_idx];
    // Signed time since the last accepted edge; bit NOW_W is the sign.
    assign w_diff = {1'b0, r_now} - {1'b0, w_last};
    assign w_deb_gt   = !w_diff[NOW_W]
                        && (w_diff[NOW_W-1:0] > NOW_W'(r_debounce));
    assign w_stale_gt = !w_diff[NOW_W]
                        && (w_diff[NOW_W-1:0] > NOW_W'(r_stale));

    assign w_edge_acc  = r_wheel_ok && (r_op == wsra_pkg::OP_EDGE) && w_deb_gt;
    // The first accepted edge of a wheel only records its time.
    assign w_smp_start = w_edge_acc && (w_last != '0);
    assign w_avg_start = r_wheel_ok && (r_op == wsra_pkg::OP_READ)
                         && (r_count[r_idx] != '0) && !w_stale_gt;

    assign w_trial = {r_rem[NOW_W-1:0], r_quo[SUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    // Until the window has wrapped, the slot under the head was never written.
    assign w_old = (r_count[r_idx] == CNT_W'(WINDOW_LEN)) ? r_mem_rd : '0;
    assign w_sum_next = r_sum[r_idx] - SUM_W'(w_old) + SUM_W'(r_quo[RPM_W-1:0]);
    assign w_head_next = (r_head[r_idx] == HD_W'(WINDOW_LEN - 1))
                         ? '0 : r_head[r_idx] + HD_W'(1);
    assign w_addr = AW'(AW'(r_idx) * AW'(WINDOW_LEN) + AW'(r_head[r_idx]));
    assign w_mem_we = (r_state == S_UPD);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_addr] <= r_quo[RPM_W-1:0];
        end
        r_mem_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= wsra_pkg::DEBOUNCE_RST;
            r_stale    <= wsra_pkg::STALE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wsra_pkg::REG_DEBOUNCE) begin
                r_debounce <= i_cfg_data;
            end else if (i_cfg_idx == wsra_pkg::REG_STALE) begin
                r_stale <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WHEELS; i++) begin
                r_last[i]  <= '0;
                r_head[i]  <= '0;
                r_count[i] <= '0;
                r_sum[i]   <= '0;
            end
        end else begin
            // In S_OUT a taken beat is replaced by the new result directly.
            if (o_out.valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op       <= i_in.operation;
                        r_wheel_ok <= 32'(i_in.wheel) < 32'(WHEELS);
                        r_idx      <= WI_W'(i_in.wheel);
                        r_now      <= i_in.now_us;
                        r_state    <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_res_avg     <= '0;
                    r_res_acc     <= w_edge_acc;
                    r_res_add     <= 1'b0;
                    r_rem         <= '0;
                    r_dcnt        <= DC_W'(SUM_W - 1);
                    r_mode_sample <= w_smp_start;
                    r_quo         <= w_smp_start ? SUM_W'(wsra_pkg::RPM_Q8_NUM)
                                                 : r_sum[r_idx];
                    r_dvs         <= w_smp_start ? w_diff[NOW_W-1:0]
                                                 : NOW_W'(r_count[r_idx]);
                    if (w_edge_acc) begin
                        r_last[r_idx] <= r_now;
                    end
                    r_state <= (w_smp_start || w_avg_start) ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    r_rem  <= w_fit ? (w_trial - {1'b0, r_dvs}) : w_trial;
                    r_quo  <= {r_quo[SUM_W-2:0], w_fit};
                    r_dcnt <= r_dcnt - DC_W'(1);
                    if (r_dcnt == '0) begin
                        r_state <= r_mode_sample ? S_UPD : S_OUT;
                        if (!r_mode_sample) begin
                            r_res_avg <= {r_quo[RPM_W-2:0], w_fit};
                        end
                    end
                end
                S_UPD: begin
                    r_sum[r_idx]  <= w_sum_next;
                    r_head[r_idx] <= w_head_next;
                    if (r_count[r_idx] != CNT_W'(WINDOW_LEN)) begin
                        r_count[r_idx] <= r_count[r_idx] + CNT_W'(1);
                    end
                    r_res_add <= 1'b1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_avg   <= r_res_avg;
                        r_out_acc   <= r_res_acc;
                        r_out_add   <= r_res_add;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.rpm_avg       = r_out_avg;
    assign o_out.edge_accepted = r_out_acc;
    assign o_out.sample_added  = r_out_add;

endmodule

[src/wsra_checker.sv]
module wsra_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [wsra_pkg::RPM_W-1:0]   i_out_avg,
    input logic                         i_out_acc,
    input logic                         i_out_add
);

    // A beat that waits on the output side keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_avg) && $stable(i_out_acc) && $stable(i_out_add))
        else $error("output beat changed while stalled");

    // A sample can only come from an edge that passed debounce.
    a_add_needs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_add |-> i_out_acc)
        else $error("sample added without an accepted edge");

    // Edge results never carry an average.
    a_edge_no_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_acc |-> i_out_avg == '0)
        else $error("edge result carries a nonzero average");

    // The block works on one beat at a time.
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a beat is in work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind wheel_speed_rpm_averager wsra_checker u_wsra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_avg   (o_out.rpm_avg),
    .i_out_acc   (o_out.edge_accepted),
    .i_out_add   (o_out.sample_added)
);

[sim/wsra_checker.sv]
`timescale 1ns / 100ps

module wsra_scoreboard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wsra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wsra_pkg::CFG_W-1:0]      i_cfg_data,
    wsra_in_if                              i_mon_in,
    wsra_out_if                             i_mon_out,
    output int                              o_err_count,
    output int                              o_pending
);

    localparam int WINDOW  = wsra_pkg::DEFAULT_WINDOW_LEN;
    localparam int WHEEL_N = wsra_pkg::DEFAULT_WHEELS;
    localparam int RPM_W   = wsra_pkg::RPM_W;
    localparam int NOW_W   = wsra_pkg::NOW_W;
    localparam int CFG_W   = wsra_pkg::CFG_W;
    localparam int WHEEL_W = wsra_pkg::WHEEL_W;

    typedef struct packed {
        logic [RPM_W-1:0] rpm_avg;
        logic             edge_accepted;
        logic             sample_added;
    } t_tach_result;

    t_tach_result     rpm_expected_q[$];
    int               mismatch_n = 0;

    logic [CFG_W-1:0] debounce_us_r;
    logic [CFG_W-1:0] stale_us_r;
    logic [NOW_W-1:0] last_edge_t [WHEEL_N];
    logic [RPM_W-1:0] rpm_ring    [WHEEL_N][WINDOW];
    int unsigned      ring_head   [WHEEL_N];
    int unsigned      ring_fill   [WHEEL_N];
    logic [63:0]      ring_sum    [WHEEL_N];

    assign o_err_count = mismatch_n;

    // Updates the per-wheel tachometer state for one input beat and returns the
    // result the block should produce for it.
    function automatic t_tach_result predict_tach(input logic op,
                                                  input logic [WHEEL_W-1:0] w,
                                                  input logic [NOW_W-1:0] now);
        t_tach_result     res;
        logic signed [63:0] age;
        logic [63:0]      sample;
        int unsigned      h;
        res = '0;
        age = $signed({16'd0, now}) - $signed({16'd0, last_edge_t[w]});
        if (op == wsra_pkg::OP_EDGE) begin
            if (age > $signed({32'd0, debounce_us_r})) begin
                res.edge_accepted = 1'b1;
                // A zero edge time means the wheel has not had an accepted edge yet.
                if (last_edge_t[w] != '0) begin
                    sample = {30'd0, wsra_pkg::RPM_Q8_NUM} / 64'(age);
                    h = ring_head[w];
                    ring_sum[w] = ring_sum[w] - {30'd0, rpm_ring[w][h]};
                    rpm_ring[w][h] = sample[RPM_W-1:0];
                    ring_sum[w] = ring_sum[w] + {30'd0, sample[RPM_W-1:0]};
                    ring_head[w] = (h + 1) % WINDOW;
                    if (ring_fill[w] < WINDOW)
                        ring_fill[w] = ring_fill[w] + 1;
                    res.sample_added = 1'b1;
                end
                last_edge_t[w] = now;
            end
        end else if (ring_fill[w] != 0 && !(age > $signed({32'd0, stale_us_r}))) begin
            sample = ring_sum[w] / 64'(ring_fill[w]);
            res.rpm_avg = sample[RPM_W-1:0];
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatch_n++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tach_result exp_r;
        if (!i_rst_n) begin
            debounce_us_r = wsra_pkg::DEBOUNCE_RST;
            stale_us_r    = wsra_pkg::STALE_RST;
            for (int w = 0; w < WHEEL_N; w++) begin
                last_edge_t[w] = '0;
                ring_head[w]   = 0;
                ring_fill[w]   = 0;
                ring_sum[w]    = '0;
                for (int s = 0; s < WINDOW; s++)
                    rpm_ring[w][s] = '0;
            end
            rpm_expected_q.delete();
            o_pending <= 0;
        end else begin
            // The result of a beat taken at this edge cannot leave at the same edge.
            if (i_mon_out.valid && i_mon_out.ready) begin
                if (rpm_expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got rpm_avg %0d",
                             $time, i_mon_out.rpm_avg);
                    mismatch_n++;
                end else begin
                    exp_r = rpm_expected_q.pop_front();
                    check_field("rpm_avg", 64'(exp_r.rpm_avg), 64'(i_mon_out.rpm_avg));
                    check_field("edge_accepted", 64'(exp_r.edge_accepted),
                                64'(i_mon_out.edge_accepted));
                    check_field("sample_added", 64'(exp_r.sample_added),
                                64'(i_mon_out.sample_added));
                end
            end
            if (i_mon_in.valid && i_mon_in.ready)
                rpm_expected_q.push_back(predict_tach(i_mon_in.operation, i_mon_in.wheel,
                                                      i_mon_in.now_us));
            if (i_cfg_we) begin
                if (i_cfg_idx == wsra_pkg::REG_DEBOUNCE)
                    debounce_us_r = i_cfg_data;
                else if (i_cfg_idx == wsra_pkg::REG_STALE)
                    stale_us_r = i_cfg_data;
            end
            o_pending <= rpm_expected_q.size();
        end
    end

endmodule

[sim/tb_wheel_speed_rpm_averager.sv]
`timescale 1ns / 100ps

module tb_wheel_speed_rpm_averager;

    localparam int DRAIN_CYCLES = 48;
    localparam int CFG_IDX_W    = wsra_pkg::CFG_IDX_W;
    localparam int CFG_W        = wsra_pkg::CFG_W;
    localparam int WHEEL_W      = wsra_pkg::WHEEL_W;
    localparam int NOW_W        = wsra_pkg::NOW_W;
    localparam int WHEEL_N      = wsra_pkg::DEFAULT_WHEELS;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   pending_n;
    int                   stall_left = 0;
    logic [9:0]           ready_cyc  = '0;
    logic [63:0]          now_t      = '0;

    wsra_in_if  in_bus ();
    wsra_out_if out_bus ();

    wheel_speed_rpm_averager u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    wsra_scoreboard u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mon_in    (in_bus),
        .i_mon_out   (out_bus),
        .o_err_count (fail_count),
        .o_pending   (pending_n)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_below(input logic [63:0] n);
        return {$urandom, $urandom} % n;
    endfunction

    // Result side: stalls are enabled three quarters of the time.
    always @(posedge i_clk) begin
        int gap;
        gap = pick_gap();
        ready_cyc <= ready_cyc + 1'b1;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_bus.ready <= 1'b0;
        end else if (ready_cyc[9:8] == 2'd0 || gap == 0) begin
            out_bus.ready <= 1'b1;
        end else begin
            out_bus.ready <= 1'b0;
            stall_left <= gap - 1;
        end
    end

    // Holds the beat until it is taken; with no gap the next call overrides it
    // in the same time step.
    task automatic send_beat(input logic op, input logic [WHEEL_W-1:0] w,
                             input logic [63:0] t, input int gap);
        in_bus.valid     <= 1'b1;
        in_bus.operation <= op;
        in_bus.wheel     <= w;
        in_bus.now_us    <= t[NOW_W-1:0];
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_n != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] stale);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wsra_pkg::REG_DEBOUNCE;
        i_cfg_data <= deb;
        @(posedge i_clk);
        i_cfg_idx  <= wsra_pkg::REG_STALE;
        i_cfg_data <= stale;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input logic [CFG_W-1:0] deb,
                             input logic [CFG_W-1:0] stale);
        logic [63:0]      scale;
        logic [63:0]      t;
        logic [63:0]      back;
        logic             op;
        logic [WHEEL_W-1:0] w;
        int               roll;
        int               gap;
        set_config(deb, stale);
        scale = (deb > stale) ? 64'(deb) : 64'(stale);
        if (scale < 16)
            scale = 16;
        if ($urandom_range(0, 1) == 1)
            now_t = now_t + rand_below(64'd1 << 44);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            op   = ($urandom_range(0, 99) < 60) ? wsra_pkg::OP_EDGE : wsra_pkg::OP_READ;
            w    = WHEEL_W'($urandom_range(0, WHEEL_N - 1));
            if (roll < 8) begin
                // Out-of-order timestamp at or behind the current time.
                back = (now_t < 2 * scale) ? now_t : 2 * scale;
                t = now_t - rand_below(back + 1);
            end else begin
                if (roll < 15)
                    now_t = now_t;
                else if (roll < 25)
                    now_t = now_t + rand_below(4 * scale + 1);
                else
                    now_t = now_t + rand_below(scale / 2 + 1);
                t = now_t;
            end
            gap = (((i / 40) % 3) == 2) ? 0 : pick_gap();
            send_beat(op, w, t, gap);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = wsra_pkg::REG_DEBOUNCE;
        i_cfg_data       = '0;
        in_bus.valid     = 1'b0;
        in_bus.operation = wsra_pkg::OP_EDGE;
        in_bus.wheel     = '0;
        in_bus.now_us    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty window, debounce boundary, first edge, stale boundary.
        send_beat(wsra_pkg::OP_READ, 2'd0, 64'd0, pick_gap());
        send_beat(wsra_pkg::OP_EDGE, 2'd0, 64'd0, pick_gap());
        send_beat(wsra_pkg::OP_EDGE, 2'd0, 64'd500000, pick_gap());
        send_beat(wsra_pkg::OP_EDGE, 2'd0, 64'd500001, pick_gap());
        send_beat(wsra_pkg::OP_READ, 2'd0, 64'd500001, pick_gap());
        send_beat(wsra_pkg::OP_EDGE, 2'd0, 64'd1000001, pick_gap());
        send_beat(wsra_pkg::OP_EDGE, 2'd0, 64'd1000002, pick_gap());
        send_beat(wsra_pkg::OP_READ, 2'd0, 64'd1000002, pick_gap());
        send_beat(wsra_pkg::OP_READ, 2'd0, 64'd2000002, pick_gap());
        send_beat(wsra_pkg::OP_READ, 2'd0, 64'd2000003, pick_gap());
        // Time going backwards: the read sees a fresh edge, the edge is rejected.
        send_beat(wsra_pkg::OP_READ, 2'd0, 64'd900000, pick_gap());
        send_beat(wsra_pkg::OP_EDGE, 2'd0, 64'd900000, pick_gap());

        // No debounce: periods of one microsecond give the largest sample and
        // wrap the window.
        set_config('0, wsra_pkg::STALE_RST);
        now_t = 64'd3000000;
        for (int k = 0; k < 10; k++)
            send_beat(wsra_pkg::OP_EDGE, 2'd1, now_t + k, pick_gap());
        now_t = now_t + 9;
        send_beat(wsra_pkg::OP_READ, 2'd1, now_t, pick_gap());

        run_phase(125, '0, '0);
        run_phase(125, '1, '1);
        run_phase(125, '0, '1);
        run_phase(125, '1, '0);
        repeat (4)
            run_phase(125, $urandom_range(1, 5000), $urandom_range(0, 20000));

        // Largest timestamp on every wheel, then a read at that time and a read far in the past.
        for (int w = 0; w < WHEEL_N; w++)
            send_beat(wsra_pkg::OP_EDGE, WHEEL_W'(w), {16'd0, {NOW_W{1'b1}}}, pick_gap());
        send_beat(wsra_pkg::OP_READ, 2'd0, {16'd0, {NOW_W{1'b1}}}, pick_gap());
        send_beat(wsra_pkg::OP_READ, 2'd1, 64'd0, pick_gap());

        wait_idle();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/wsra_pkg.sv
src/wsra_in_if.sv
src/wsra_out_if.sv
src/wheel_speed_rpm_averager.sv
src/wsra_checker.sv
sim/wsra_checker.sv
sim/tb_wheel_speed_rpm_averager.sv
